FILE: hw/rtl/char_lcd_text_writer_macros.svh
// Assertion macros shared by the text writer RTL.
// Each macro expects clk and rst_n in scope of the using module.
`ifndef CHAR_LCD_TEXT_WRITER_MACROS_SVH
`define CHAR_LCD_TEXT_WRITER_MACROS_SVH

// Same-cycle implication, off during reset.
`define LCDTW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define LCDTW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/lcdtw_pkg.sv
// Shared types, register codes and constants for the character LCD text writer.
// No dependencies; used by lcdtw_fmt and char_lcd_text_writer.
package lcdtw_pkg;

  localparam int COL_W     = 6;
  localparam int ROW_W     = 2;
  localparam int CURCOL_W  = 7;
  localparam int NCOLS_W   = 6;
  localparam int NROWS_W   = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'd1;

  localparam logic [NCOLS_W-1:0] NUM_COLS_RST = 6'd16;
  localparam logic [NROWS_W-1:0] NUM_ROWS_RST = 3'd2;

  localparam logic REQ_POSITION = 1'b0;
  localparam logic REQ_CHAR     = 1'b1;

  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  localparam logic [7:0] CMD_SET_ADDR = 8'h80;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;

  localparam logic [6:0] ROW1_BASE = 7'h40;
  localparam logic [6:0] ROW2_BASE = 7'h14;
  localparam logic [6:0] ROW3_BASE = 7'h54;

  typedef struct packed {
    logic             req_type;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [7:0]       char_code;
  } lcdtw_in_t;

  typedef struct packed {
    logic       reg_select;
    logic [3:0] nibble;
    logic       last;
  } lcdtw_out_t;

  // One request's bus bytes: one or two bytes, each with its select bit.
  typedef struct packed {
    logic       rs0;
    logic [7:0] byte0;
    logic       rs1;
    logic [7:0] byte1;
    logic       two;
  } lcdtw_job_t;

endpackage

FILE: hw/rtl/lcdtw_fmt.sv
// Request formatter: turns one request and the cursor into bus bytes and a new cursor.
// Depends on lcdtw_pkg.
module lcdtw_fmt import lcdtw_pkg::*; (
  input  lcdtw_in_t           req,
  input  logic [CURCOL_W-1:0] cur_col,
  input  logic [ROW_W-1:0]    cur_row,
  input  logic [NCOLS_W-1:0]  num_cols,
  input  logic [NROWS_W-1:0]  num_rows,
  output lcdtw_job_t          job,
  output logic [CURCOL_W-1:0] nxt_col,
  output logic [ROW_W-1:0]    nxt_row
);

  function automatic logic [ROW_W-1:0] fit_row(input logic [NROWS_W-1:0] r,
                                               input logic [NROWS_W-1:0] nrows);
    if (r[2] || r >= nrows) begin
      return '0;
    end
    return r[ROW_W-1:0];
  endfunction

  function automatic logic [7:0] addr_cmd(input logic [CURCOL_W-1:0] c,
                                          input logic [ROW_W-1:0] r);
    logic [6:0] base;
    case (r)
      2'd1:    base = ROW1_BASE;
      2'd2:    base = ROW2_BASE;
      2'd3:    base = ROW3_BASE;
      default: base = '0;
    endcase
    return CMD_SET_ADDR | {1'b0, 7'(c + base)};
  endfunction

  logic                wrap;
  logic [CURCOL_W-1:0] col1;
  logic [ROW_W-1:0]    row1;
  logic [ROW_W-1:0]    pos_row;
  logic [ROW_W-1:0]    nl_row;
  logic [ROW_W-1:0]    cr_row;

  assign wrap    = cur_col >= {1'b0, num_cols};
  assign pos_row = fit_row({1'b0, req.row}, num_rows);
  assign col1    = wrap ? '0 : cur_col;
  assign row1    = wrap ? fit_row(NROWS_W'({1'b0, cur_row} + 3'd1), num_rows) : cur_row;
  assign nl_row  = fit_row(NROWS_W'({1'b0, row1} + 3'd1), num_rows);
  assign cr_row  = fit_row({1'b0, row1}, num_rows);

  always_comb begin
    logic       rs2;
    logic [7:0] byte2;
    job     = '0;
    nxt_col = cur_col;
    nxt_row = cur_row;
    rs2     = RS_CMD;
    byte2   = '0;
    if (req.req_type == REQ_POSITION) begin
      nxt_col   = {1'b0, req.col};
      nxt_row   = pos_row;
      job.rs0   = RS_CMD;
      job.byte0 = addr_cmd({1'b0, req.col}, pos_row);
    end else begin
      // Work out the byte after any wrap, then place it behind the wrap command.
      if (req.char_code == CH_NEWLINE) begin
        nxt_col = col1;
        nxt_row = nl_row;
        byte2   = addr_cmd(col1, nl_row);
      end else if (req.char_code == CH_RETURN) begin
        nxt_col = '0;
        nxt_row = cr_row;
        byte2   = addr_cmd('0, cr_row);
      end else begin
        nxt_col = col1 + 7'd1;
        nxt_row = row1;
        rs2     = RS_DATA;
        byte2   = req.char_code;
      end
      if (wrap) begin
        job.rs0   = RS_CMD;
        job.byte0 = addr_cmd('0, row1);
        job.rs1   = rs2;
        job.byte1 = byte2;
        job.two   = 1'b1;
      end else begin
        job.rs0   = rs2;
        job.byte0 = byte2;
      end
    end
  end

endmodule

FILE: hw/rtl/char_lcd_text_writer.sv
// Character LCD text writer top level: input register, formatter, nibble sequencer.
// Depends on lcdtw_pkg, lcdtw_fmt and char_lcd_text_writer_macros.svh.
//
//   channel | direction | handshake         | payload
//   in_     | in        | in_valid/in_stall | lcdtw_in_t (request)
//   out_    | out       | out_valid/out_stall | lcdtw_out_t (one nibble)
//   cfg_    | in        | cfg_we            | cfg_index, cfg_wdata
//
// A request sits in the input register, then is formatted into the job register,
// which sends one nibble a cycle unless out_stall is high: two nibbles for a plain
// request, four when a line wrap adds an address command. The job register frees on
// its last nibble, so the next request loads in the same cycle with no gap.
// Reset: cursor at column 0 row 0, num_cols 16, num_rows 2, both stages empty.
// out_stall holds the current nibble; in_stall is high while the input register
// is full and the job register cannot take its request in that cycle.
`include "char_lcd_text_writer_macros.svh"
module char_lcd_text_writer import lcdtw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lcdtw_in_t            in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lcdtw_out_t           out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  logic                in_valid_r;
  lcdtw_in_t           in_req_r;
  logic                job_valid_r;
  lcdtw_job_t          job_r;
  logic [1:0]          idx_r;
  logic [CURCOL_W-1:0] col_r;
  logic [ROW_W-1:0]    row_r;
  logic [NCOLS_W-1:0]  num_cols_r;
  logic [NROWS_W-1:0]  num_rows_r;

  lcdtw_job_t          job_nxt;
  logic [CURCOL_W-1:0] col_nxt;
  logic [ROW_W-1:0]    row_nxt;

  logic in_acc;
  logic out_acc;
  logic job_done;
  logic job_free;
  logic load;
  logic cur_last;
  logic [7:0] cur_byte;

  lcdtw_fmt u_fmt (
    .req      (in_req_r),
    .cur_col  (col_r),
    .cur_row  (row_r),
    .num_cols (num_cols_r),
    .num_rows (num_rows_r),
    .job      (job_nxt),
    .nxt_col  (col_nxt),
    .nxt_row  (row_nxt)
  );

  assign cur_last = idx_r == {job_r.two, 1'b1};
  assign out_acc  = job_valid_r && !out_stall;
  assign job_done = out_acc && cur_last;
  assign job_free = !job_valid_r || job_done;
  assign load     = in_valid_r && job_free;
  assign in_stall = in_valid_r && !job_free;
  assign in_acc   = in_valid && !in_stall;

  assign cur_byte            = idx_r[1] ? job_r.byte1 : job_r.byte0;
  assign out_valid           = job_valid_r;
  assign out_data.reg_select = idx_r[1] ? job_r.rs1 : job_r.rs0;
  assign out_data.nibble     = idx_r[0] ? cur_byte[3:0] : cur_byte[7:4];
  assign out_data.last       = cur_last;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cols_r <= NUM_COLS_RST;
      num_rows_r <= NUM_ROWS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_COLS: num_cols_r <= cfg_wdata[NCOLS_W-1:0];
        REG_NUM_ROWS: num_rows_r <= cfg_wdata[NROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_acc) begin
      in_valid_r <= 1'b1;
    end else if (load) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_req_r <= in_data;
    end
  end

  // Cursor advances when a request moves into the job register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (load) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Job register and nibble index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      job_valid_r <= 1'b1;
      idx_r       <= '0;
    end else if (job_done) begin
      job_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (out_acc) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= job_nxt;
    end
  end

  `LCDTW_ASSERT_NOW(a_one_byte_idx, job_valid_r && !job_r.two, !idx_r[1], "index past job end")
  `LCDTW_ASSERT_NEXT(a_cursor_hold, !load, $stable(col_r) && $stable(row_r), "cursor moved")
  `LCDTW_ASSERT_NEXT(a_no_gap, job_done && in_valid_r, out_valid, "gap behind finished job")
  `LCDTW_ASSERT_NOW(a_stall_busy, in_stall, in_valid_r && out_valid, "stall with output idle")

endmodule
